// ===== rtl/mrs_pkg.sv =====
// Shared types and constants for the minimum refuel stops unit.
// Used by the cells, the hit search, the top level and the port checker.
package mrs_pkg;

  localparam int MAX_STATIONS = 512;
  localparam int NUM_ENTRIES  = MAX_STATIONS + 1;

  localparam int DATA_W  = 32;
  localparam int REACH_W = 48;
  localparam int STOPS_W = 10;
  localparam int IDX_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  // Two-level search over the hit flags: groups of GRP_W, then across groups.
  localparam int GRP_W     = 32;
  localparam int SUB_W     = $clog2(GRP_W);
  localparam int NUM_GRP   = (NUM_ENTRIES + GRP_W - 1) / GRP_W;
  localparam int GRP_IDX_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;

  localparam int CFG_IDX_W = 2;

  localparam logic                 CMD_STATION    = 1'b0;
  localparam logic                 CMD_FINISH     = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FUEL = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROUP,
    ST_FINAL
  } state_t;

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic              upd;
    logic              clr;
    logic [DATA_W-1:0] pos;
    logic [DATA_W-1:0] fuel;
    logic [DATA_W-1:0] target;
  } cell_ctrl_t;

endpackage

// ===== rtl/min_refuel_stops_dp_unit.sv =====
// Minimum refuel stops unit: top level with handshakes, registers and control.
// Depends on mrs_pkg, mrs_cell and mrs_find.
//
// Station words stream in ordered by position, and each one updates a chain of
// MAX_STATIONS cells at once, so station words are taken back to back
// while the unit is idle. Cell j holds the farthest distance reachable with
// exactly j refuels and updates from its own value and that of cell j-1; the
// reach with no refuels is the start_fuel register itself. Stations beyond
// capacity are dropped and reported with the next answer. A finish word passes
// through registered steps to its answer word: a compare of every cell against
// the target, the per-group search over 32 cells, and the choice of the lowest
// group with the load of the output register. That last step waits if an
// earlier answer has not been taken. No input word is taken between a finish
// word and the loading of its answer. The finish word also empties the table
// at once, so there is no clearing pass after reset or between runs.
// Configuration writes are always taken; write them only while idle.
module min_refuel_stops_dp_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic [mrs_pkg::DATA_W-1:0]         station_position,
  input  logic [mrs_pkg::DATA_W-1:0]         station_fuel,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mrs_pkg::STOPS_W-1:0]        min_stops,
  output logic                               reachable,
  output logic                               too_many_stations,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrs_pkg::DATA_W-1:0]         cfg_data
);
  import mrs_pkg::*;

  state_t state;
  state_t state_next;

  logic [DATA_W-1:0] target_distance;
  logic [DATA_W-1:0] start_fuel;
  logic              overflow_seen;
  logic              ovf_hold;
  logic              hit0;

  logic              in_accept;
  logic              station_acc;
  logic              finish_acc;
  logic              table_full;
  logic              load_out;
  cell_ctrl_t        cell_ctrl;

  logic [REACH_W-1:0]     reach_w [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] active_w;
  logic [NUM_ENTRIES-1:0] hits;

  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [31:0]       idx_wide;

  assign in_ready    = (state == ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign in_accept   = in_valid && in_ready;
  assign station_acc = in_accept && (command == CMD_STATION);
  assign finish_acc  = in_accept && (command == CMD_FINISH);

  // The last cell turns active once the table holds MAX_STATIONS stations.
  assign table_full = active_w[MAX_STATIONS];

  always_comb begin
    cell_ctrl.upd    = station_acc && !table_full;
    cell_ctrl.clr    = finish_acc;
    cell_ctrl.pos    = station_position;
    cell_ctrl.fuel   = station_fuel;
    cell_ctrl.target = target_distance;
  end

  // Entry zero of the chain is the start fuel, always active.
  assign reach_w[0]  = REACH_W'(start_fuel);
  assign active_w[0] = 1'b1;
  assign hits[0]     = hit0;

  for (genvar j = 1; j < NUM_ENTRIES; j++) begin : g_cell
    mrs_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (cell_ctrl),
      .below_reach  (reach_w[j-1]),
      .below_active (active_w[j-1]),
      .reach        (reach_w[j]),
      .active       (active_w[j]),
      .hit          (hits[j])
    );
  end

  mrs_find u_find (
    .clk    (clk),
    .grp_en (state == ST_GROUP),
    .hits   (hits),
    .found  (found),
    .idx    (found_idx)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_distance <= DATA_W'(1);
      start_fuel      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET:     target_distance <= cfg_data;
        REG_START_FUEL: start_fuel      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Dropped-station flag for the current run.
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (finish_acc) begin
      overflow_seen <= 1'b0;
    end else if (station_acc && table_full) begin
      overflow_seen <= 1'b1;
    end
  end

  // Snapshot taken with the finish word, alongside the cells' hit flags.
  always_ff @(posedge clk) begin
    if (finish_acc) begin
      ovf_hold <= overflow_seen;
      hit0     <= (start_fuel >= target_distance);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (finish_acc) begin
          state_next = ST_GROUP;
        end
      end
      ST_GROUP: begin
        state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign idx_wide = 32'(found_idx);

  // Output register: holds the answer word until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      min_stops         <= found ? idx_wide[STOPS_W-1:0] : '0;
      reachable         <= found;
      too_many_stations <= ovf_hold;
    end
  end

endmodule

// ===== rtl/mrs_cell.sv =====
// One table entry of the reach chain: farthest reach for a fixed refuel count.
// Depends on mrs_pkg; reads the reach and active flag of its lower neighbor.
module mrs_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  mrs_pkg::cell_ctrl_t              ctrl,
  input  logic [mrs_pkg::REACH_W-1:0]      below_reach,
  input  logic                             below_active,
  output logic [mrs_pkg::REACH_W-1:0]      reach,
  output logic                             active,
  output logic                             hit
);
  import mrs_pkg::*;

  logic [REACH_W-1:0] here;
  logic [REACH_W-1:0] pos_ext;
  logic [REACH_W-1:0] cand;
  logic [REACH_W-1:0] best;
  logic [REACH_W:0]   sum;

  // An inactive entry holds no stations yet and reads as zero.
  always_comb begin
    here    = active ? reach : '0;
    pos_ext = REACH_W'(ctrl.pos);
    sum     = {1'b0, below_reach} + (REACH_W + 1)'(ctrl.fuel);
    cand    = '0;
    if (below_reach >= pos_ext) begin
      cand = sum[REACH_W] ? '1 : sum[REACH_W-1:0];
    end
    best = cand;
    if ((here >= pos_ext) && (here > cand)) begin
      best = here;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctrl.clr) begin
      active <= 1'b0;
    end else if (ctrl.upd) begin
      active <= below_active;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd && below_active) begin
      reach <= best;
    end
    if (ctrl.clr) begin
      hit <= active && (reach >= REACH_W'(ctrl.target));
    end
  end

endmodule

// ===== rtl/mrs_find.sv =====
// Registered two-level search for the lowest set hit flag.
// Depends on mrs_pkg; group results are registered, the final pick is combinational.
module mrs_find (
  input  logic                             clk,
  input  logic                             grp_en,
  input  logic [mrs_pkg::NUM_ENTRIES-1:0]  hits,
  output logic                             found,
  output logic [mrs_pkg::IDX_W-1:0]        idx
);
  import mrs_pkg::*;

  logic [NUM_GRP*GRP_W-1:0] hits_pad;
  logic [NUM_GRP-1:0]       grp_any_d;
  logic [SUB_W-1:0]         grp_sub_d [NUM_GRP];
  logic [NUM_GRP-1:0]       grp_any;
  logic [SUB_W-1:0]         grp_sub [NUM_GRP];
  logic [GRP_IDX_W-1:0]     sel_g;
  logic [SUB_W-1:0]         sel_sub;

  always_comb begin
    hits_pad = (NUM_GRP * GRP_W)'(hits);
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_any_d[g] = 1'b0;
      grp_sub_d[g] = '0;
      for (int i = GRP_W - 1; i >= 0; i--) begin
        if (hits_pad[g*GRP_W + i]) begin
          grp_any_d[g] = 1'b1;
          grp_sub_d[g] = SUB_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_en) begin
      grp_any <= grp_any_d;
      for (int g = 0; g < NUM_GRP; g++) begin
        grp_sub[g] <= grp_sub_d[g];
      end
    end
  end

  always_comb begin
    found   = 1'b0;
    sel_g   = '0;
    sel_sub = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found   = 1'b1;
        sel_g   = GRP_IDX_W'(g);
        sel_sub = grp_sub[g];
      end
    end
    idx = IDX_W'({sel_g, sel_sub});
  end

endmodule

// ===== rtl/mrs_checker.sv =====
// Port-level checks for the minimum refuel stops unit, bound to the top level.
// Depends on mrs_pkg and on the port list of min_refuel_stops_dp_unit.
module mrs_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               command,
  input logic [mrs_pkg::DATA_W-1:0]         station_position,
  input logic [mrs_pkg::DATA_W-1:0]         station_fuel,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [mrs_pkg::STOPS_W-1:0]        min_stops,
  input logic                               reachable,
  input logic                               too_many_stations,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [mrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [mrs_pkg::DATA_W-1:0]         cfg_data
);
  import mrs_pkg::*;

  // A waiting answer word holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(min_stops) &&
      $stable(reachable) && $stable(too_many_stations))
    else $error("answer word changed while stalled");

  // An unreachable target always reports zero stops.
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reachable |-> min_stops == '0)
    else $error("nonzero stop count with unreachable target");

  // Nothing new is taken while a finish word is being answered.
  a_finish_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_FINISH |=> !in_ready)
    else $error("input taken right after a finish word");

  // A station word never produces an answer word.
  a_station_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_STATION && !out_valid |=> !out_valid)
    else $error("answer word appeared after a station word");

endmodule

bind min_refuel_stops_dp_unit mrs_checker u_mrs_checker (.*);

// ===== dv/min_refuel_stops_dp_unit_tb.sv =====
// Self-checking testbench for min_refuel_stops_dp_unit.
// Needs only the RTL and mrs_pkg; it predicts each answer word from its own copy
// of the reach table and checks the words from the output port in order.
module min_refuel_stops_dp_unit_tb;
  import mrs_pkg::*;

  // Percent of cycles in which either side idles while idling is enabled.
  localparam int IDLE_PCT = 8;
  // Cycles the receiver refuses answers during the back-pressure test.
  localparam int HOLD_CYCLES = 300;
  // A finish word and the last station update must settle before a register
  // write; DRAIN_CYCLES quiet cycles after the last answer cover both.
  localparam int DRAIN_CYCLES = 8;
  // Register indexes that the unit does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // One answer word, as the output ports show it.
  typedef struct packed {
    logic [STOPS_W-1:0] stops;
    logic               reach;
    logic               dropped;
  } answer_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 command = CMD_STATION;
  logic [DATA_W-1:0]    station_position = '0;
  logic [DATA_W-1:0]    station_fuel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STOPS_W-1:0]   min_stops;
  logic                 reachable;
  logic                 too_many_stations;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TARGET;
  logic [DATA_W-1:0]    cfg_data = '0;

  min_refuel_stops_dp_unit dut (.*);

  // Predicted state of the unit: the reach table, the station count of the
  // current trip, the overflow flag and both registers.
  logic [REACH_W-1:0] reach_tbl [NUM_ENTRIES];
  int                 stations_taken;
  logic               dropped_any;
  logic [DATA_W-1:0]  tgt_reg = 32'd1;
  logic [DATA_W-1:0]  fuel_reg = '0;

  // Answers predicted at each accepted finish word, oldest first.
  answer_t pending_answers [$];

  // Idling control shared by the sender and the receiver.
  bit idle_on = 1'b1;
  // The back-pressure test bumps hold_asks; the receiver notices the change and
  // counts its own hold-off cycles.
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int mismatches = 0;
  int answers_checked = 0;
  int stations_sent = 0;
  int finishes_sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Empty the table for a new trip. Entry 0 always mirrors start_fuel.
  function void clear_trip();
    foreach (reach_tbl[j]) reach_tbl[j] = '0;
    reach_tbl[0] = REACH_W'(fuel_reg);
    stations_taken = 0;
    dropped_any = 1'b0;
  endfunction

  // Fold one station into the table. Entries are visited from the top down so
  // that each entry sees the old values of itself and the entry below it.
  function void take_station(logic [DATA_W-1:0] pos, logic [DATA_W-1:0] fuel);
    logic [REACH_W:0]   sum;
    logic [REACH_W-1:0] best;
    if (stations_taken >= MAX_STATIONS) begin
      dropped_any = 1'b1;
      return;
    end
    for (int j = stations_taken + 1; j >= 1; j--) begin
      best = '0;
      if (reach_tbl[j-1] >= pos) begin
        sum = {1'b0, reach_tbl[j-1]} + (REACH_W + 1)'(fuel);
        best = sum[REACH_W] ? '1 : sum[REACH_W-1:0];
      end
      if (reach_tbl[j] >= pos && reach_tbl[j] > best) best = reach_tbl[j];
      reach_tbl[j] = best;
    end
    stations_taken++;
  endfunction

  // The answer for the current trip: the fewest refuels whose reach meets the
  // target. The trip is then cleared, while the registers stay as they are.
  function answer_t finish_trip();
    answer_t ans;
    ans = '0;
    for (int j = 0; j <= stations_taken; j++) begin
      if (reach_tbl[j] >= tgt_reg) begin
        ans.stops = STOPS_W'(j);
        ans.reach = 1'b1;
        break;
      end
    end
    ans.dropped = dropped_any;
    clear_trip();
    return ans;
  endfunction

  // Offer one word on the input port and hold it until it is taken. Valid is
  // left high so that the next word can follow in the very next cycle.
  task automatic send_word(input logic cmd, input logic [DATA_W-1:0] pos,
                           input logic [DATA_W-1:0] fuel);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    station_position <= pos;
    station_fuel <= fuel;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_STATION) begin
      take_station(pos, fuel);
      stations_sent++;
    end else begin
      pending_answers.push_back(finish_trip());
      finishes_sent++;
    end
  endtask

  // Write one register. The caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TARGET) begin
      tgt_reg = val;
    end else if (idx == REG_START_FUEL) begin
      // The zero-refuel reach follows start_fuel at once, even mid-trip.
      fuel_reg = val;
      reach_tbl[0] = REACH_W'(val);
    end
  endtask

  // Stop offering words and let the unit go quiet: every answer in and the
  // last station update settled.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [DATA_W-1:0] target, input logic [DATA_W-1:0] fuel);
    wait_drain();
    write_reg(REG_TARGET, target);
    write_reg(REG_START_FUEL, fuel);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random short stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Answer checker: every word taken from the output is compared with the
  // oldest prediction, one field at a time.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("answer word with none expected: min_stops %0d reachable %0d too_many %0d",
               min_stops, reachable, too_many_stations);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (min_stops !== want.stops) begin
          $error("min_stops: expected %0d, got %0d", want.stops, min_stops);
          mismatches++;
        end
        if (reachable !== want.reach) begin
          $error("reachable: expected %0d, got %0d", want.reach, reachable);
          mismatches++;
        end
        if (too_many_stations !== want.dropped) begin
          $error("too_many_stations: expected %0d, got %0d", want.dropped, too_many_stations);
          mismatches++;
        end
      end
    end
  end

  // Right after reset the target is 1 and start_fuel is 0, so an empty trip
  // cannot make it, while one station at the origin can.
  task automatic test_after_reset();
    send_word(CMD_FINISH, '0, '0);
    send_word(CMD_STATION, '0, 32'd5);
    send_word(CMD_FINISH, '1, '1);
  endtask

  // Both registers at their extremes, a target of zero, and writes to
  // undecoded indexes, which must leave both registers alone.
  task automatic test_register_edges();
    set_regs('1, '1);
    send_word(CMD_FINISH, '0, '0);
    set_regs('0, '0);
    send_word(CMD_FINISH, '0, '0);
    wait_drain();
    write_reg(REG_TARGET, 32'd1);
    write_reg(REG_START_FUEL, '0);
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    cfg_valid <= 1'b0;
    send_word(CMD_FINISH, '0, '0);
  endtask

  // Field extremes, a station exactly at the edge of reach, and positions
  // that run backwards.
  task automatic test_field_edges();
    set_regs('1, '0);
    send_word(CMD_STATION, '0, '1);
    send_word(CMD_STATION, '1, '1);
    send_word(CMD_STATION, '1, '0);
    send_word(CMD_FINISH, '0, '0);
    set_regs(32'd101, 32'd100);
    send_word(CMD_STATION, 32'd100, 32'd1);
    send_word(CMD_FINISH, '0, '0);
    set_regs(32'd300, 32'd100);
    send_word(CMD_STATION, 32'd150, 32'd500);
    send_word(CMD_STATION, 32'd50, 32'd200);
    send_word(CMD_STATION, 32'd100, '0);
    send_word(CMD_FINISH, '0, '0);
  endtask

  // Rewriting start_fuel in the middle of a trip moves only the zero-refuel
  // entry; first upward, then downward.
  task automatic test_midtrip_start_fuel();
    set_regs(32'd1000, 32'd10);
    send_word(CMD_STATION, 32'd5, 32'd50);
    wait_drain();
    write_reg(REG_START_FUEL, 32'd2000);
    cfg_valid <= 1'b0;
    send_word(CMD_FINISH, '0, '0);
    send_word(CMD_STATION, '0, 32'd7);
    wait_drain();
    write_reg(REG_START_FUEL, '0);
    cfg_valid <= 1'b0;
    send_word(CMD_STATION, 32'd1, 32'd1000);
    send_word(CMD_FINISH, '0, '0);
  endtask

  // Fill the table past capacity with unit-fuel stations at the origin, so
  // that entry j reaches exactly j and the answer is the deepest entry. The
  // next trip must come back with the overflow flag cleared.
  task automatic test_capacity();
    set_regs(MAX_STATIONS, '0);
    repeat (MAX_STATIONS + 2) send_word(CMD_STATION, '0, 32'd1);
    send_word(CMD_FINISH, '0, '0);
    send_word(CMD_FINISH, '0, '0);
  endtask

  // The receiver holds off for a long stretch while short trips keep coming
  // with no gaps, so answers back up and the unit stops taking input.
  task automatic test_back_pressure();
    set_regs(32'd1500, 32'd400);
    idle_on = 1'b0;
    hold_asks++;
    repeat (30) begin
      send_word(CMD_STATION, $urandom_range(0, 1000), $urandom_range(0, 1000));
      send_word(CMD_FINISH, $urandom, $urandom);
    end
    wait_drain();
    idle_on = 1'b1;
  endtask

  // One random trip. Most trips are well formed: stations in order of
  // position, spread over the target distance, with fuel on the same scale.
  // Noisy trips use raw random positions and fuel in any order.
  task automatic random_trip(input bit rewrite, input bit noisy, inout int budget);
    int unsigned       bits;
    int unsigned       count;
    int unsigned       gap_max;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] goal;
    logic [DATA_W-1:0] pos;
    logic [DATA_W-1:0] fuel;
    longint unsigned   walk;
    if (rewrite) begin
      bits = $urandom_range(1, 32);
      mask = (bits == 32) ? '1 : (32'd1 << bits) - 32'd1;
      goal = $urandom & mask;
      if (goal == 0) goal = 32'd1;
      set_regs(goal, $urandom_range(0, goal / 2));
    end
    goal = (tgt_reg == 0) ? 32'd1 : tgt_reg;
    count = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 10) : $urandom_range(11, 48);
    walk = (longint'(goal) / (count + 1)) * 2;
    gap_max = (walk > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : walk[31:0];
    walk = 0;
    repeat (count) begin
      if (noisy) begin
        pos = $urandom;
        fuel = $urandom;
      end else begin
        walk += $urandom_range(0, gap_max);
        pos = (walk > 64'hFFFF_FFFF) ? '1 : walk[DATA_W-1:0];
        fuel = $urandom_range(0, goal / 2);
      end
      send_word(CMD_STATION, pos, fuel);
      budget--;
    end
    send_word(CMD_FINISH, $urandom, $urandom);
    budget--;
  endtask

  task automatic test_random_trips(input int words, input bit idles);
    int left;
    left = words;
    idle_on = idles;
    while (left > 0) random_trip($urandom_range(0, 1), $urandom_range(0, 99) < 15, left);
    idle_on = 1'b1;
  endtask

  initial begin
    clear_trip();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_register_edges();
    test_field_edges();
    test_midtrip_start_fuel();
    test_capacity();
    test_back_pressure();
    // A long burst with neither side idling, then the bulk with idling on.
    test_random_trips(100, 1'b0);
    test_random_trips(300, 1'b1);
    wait_drain();
    $display("Checked %0d answers from %0d station and %0d finish words.",
             answers_checked, stations_sent, finishes_sent);
    $display("Runs covered register extremes, capacity overflow and a long output hold-off.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // A time limit that stops a hang.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
